@@ hw/rtl/igpc_pkg.sv @@
// ----------------------------------------------------------------------------
// igpc_pkg: shared types and constants of the interior grain pixel counter
// Register map, pass modes, default sizes and controller/datapath signals.
// ----------------------------------------------------------------------------
`default_nettype none

package igpc_pkg;

  // Default sizes
  localparam int LABEL_BITS_DEF = 12;
  localparam int COORD_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed field widths
  localparam int GRAIN_LABEL_BITS = 32;
  localparam int CFG_DATA_BITS    = 32;
  localparam int CFG_ADDR_BITS    = 5;
  localparam int CFG_INDEX_BITS   = 3;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_LOW_X  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_LOW_Y  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_LOW_Z  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_HIGH_X = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_HIGH_Y = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_HIGH_Z = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THREE_DIM  = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PASS_MODE  = 3'd7;

  // Register reset values
  localparam int BOX_LOW_RESET  = 0;
  localparam int BOX_HIGH_RESET = 255;

  // Pass modes; the unused code behaves as a query
  localparam logic [1:0] MODE_MARK  = 2'd0;
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;  // write zero at the sweep address
    logic accept;    // capture the item and read its table entry
    logic commit;    // update table and totals, load the result register
  } igpc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;  // sweep is at the last entry
    logic out_free;    // result register can take a new item
  } igpc_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/igpc_in_if.sv @@
// ----------------------------------------------------------------------------
// igpc_in_if: voxel input channel
// Valid/ready channel carrying the voxel coordinates and its grain label.
// ----------------------------------------------------------------------------
`default_nettype none

interface igpc_in_if
  import igpc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [GRAIN_LABEL_BITS-1:0]  grain_label;

  modport source (output valid, pos_x, pos_y, pos_z, grain_label, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, grain_label, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/igpc_out_if.sv @@
// ----------------------------------------------------------------------------
// igpc_out_if: result channel
// Valid/ready channel carrying one result item per voxel.
// ----------------------------------------------------------------------------
`default_nettype none

interface igpc_out_if
  import igpc_pkg::*;
#(
  parameter int LABEL_BITS = LABEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  inside_box;
  logic                  on_face;
  logic                  label_out_of_range;
  logic                  label_is_boundary;
  logic [COUNT_BITS-1:0] label_pixels;
  logic [LABEL_BITS:0]   interior_labels;
  logic [LABEL_BITS:0]   boundary_labels;

  modport source (output valid, inside_box, on_face, label_out_of_range,
                  label_is_boundary, label_pixels, interior_labels,
                  boundary_labels, input ready);
  modport sink   (input valid, inside_box, on_face, label_out_of_range,
                  label_is_boundary, label_pixels, interior_labels,
                  boundary_labels, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/igpc_cfg.sv @@
// ----------------------------------------------------------------------------
// igpc_cfg: configuration register file
// APB-style write/read of the region box, dimension select and pass mode.
// ----------------------------------------------------------------------------
`default_nettype none

module igpc_cfg
  import igpc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [CFG_DATA_BITS-1:0]  pwdata,
  output logic      [CFG_DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output logic signed [COORD_BITS-1:0]   box_lo [3],
  output logic signed [COORD_BITS-1:0]   box_hi [3],
  output logic                           three_dim,
  output logic [1:0]                     pass_mode
);

  logic signed [COORD_BITS-1:0] box_lo_r [3];
  logic signed [COORD_BITS-1:0] box_hi_r [3];
  logic                         three_dim_r;
  logic [1:0]                   pass_mode_r;
  logic [CFG_INDEX_BITS-1:0]    reg_idx;
  logic                         wr_en;

  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        box_lo_r[a] <= COORD_BITS'(BOX_LOW_RESET);
        box_hi_r[a] <= COORD_BITS'(BOX_HIGH_RESET);
      end
      three_dim_r <= 1'b1;
      pass_mode_r <= MODE_MARK;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BOX_LOW_X:  box_lo_r[0] <= pwdata[COORD_BITS-1:0];
        REG_BOX_LOW_Y:  box_lo_r[1] <= pwdata[COORD_BITS-1:0];
        REG_BOX_LOW_Z:  box_lo_r[2] <= pwdata[COORD_BITS-1:0];
        REG_BOX_HIGH_X: box_hi_r[0] <= pwdata[COORD_BITS-1:0];
        REG_BOX_HIGH_Y: box_hi_r[1] <= pwdata[COORD_BITS-1:0];
        REG_BOX_HIGH_Z: box_hi_r[2] <= pwdata[COORD_BITS-1:0];
        REG_THREE_DIM:  three_dim_r <= pwdata[0];
        REG_PASS_MODE:  pass_mode_r <= pwdata[1:0];
        default:        ;
      endcase
    end
  end

  // Read back, coordinates sign-extended
  always_comb begin
    unique case (reg_idx)
      REG_BOX_LOW_X:  prdata = CFG_DATA_BITS'(box_lo_r[0]);
      REG_BOX_LOW_Y:  prdata = CFG_DATA_BITS'(box_lo_r[1]);
      REG_BOX_LOW_Z:  prdata = CFG_DATA_BITS'(box_lo_r[2]);
      REG_BOX_HIGH_X: prdata = CFG_DATA_BITS'(box_hi_r[0]);
      REG_BOX_HIGH_Y: prdata = CFG_DATA_BITS'(box_hi_r[1]);
      REG_BOX_HIGH_Z: prdata = CFG_DATA_BITS'(box_hi_r[2]);
      REG_THREE_DIM:  prdata = CFG_DATA_BITS'(three_dim_r);
      REG_PASS_MODE:  prdata = CFG_DATA_BITS'(pass_mode_r);
      default:        prdata = '0;
    endcase
  end

  assign box_lo    = box_lo_r;
  assign box_hi    = box_hi_r;
  assign three_dim = three_dim_r;
  assign pass_mode = pass_mode_r;

endmodule

`default_nettype wire

@@ hw/rtl/igpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// igpc_ctrl: sequencing controller
// Runs the table clearing sweep, then accepts one item and commits it.
// ----------------------------------------------------------------------------
`default_nettype none

module igpc_ctrl
  import igpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire igpc_sts_t sts,
  output igpc_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t state_r;
  logic   ready_r;

  // Commands follow the state and the handshakes
  always_comb begin
    cmd.clear_en = (state_r == ST_CLEAR);
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.commit   = (state_r == ST_UPDATE) && sts.out_free;
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ready_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (sts.clear_done) begin
            state_r <= ST_IDLE;
            ready_r <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_UPDATE;
            ready_r <= 1'b0;
          end
        end
        ST_UPDATE: begin
          if (sts.out_free) begin
            state_r <= ST_IDLE;
            ready_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
          ready_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready = ready_r;

endmodule

`default_nettype wire

@@ hw/rtl/igpc_dp.sv @@
// ----------------------------------------------------------------------------
// igpc_dp: label table datapath
// Box test, mark/count table with read-modify-write, totals, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module igpc_dp
  import igpc_pkg::*;
#(
  parameter int LABEL_BITS = LABEL_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire igpc_cmd_t                     cmd,
  output igpc_sts_t                          sts,
  input  wire logic signed [COORD_BITS-1:0]  box_lo [3],
  input  wire logic signed [COORD_BITS-1:0]  box_hi [3],
  input  wire logic                          three_dim,
  input  wire logic [1:0]                    pass_mode,
  input  wire logic signed [COORD_BITS-1:0]  in_pos_x,
  input  wire logic signed [COORD_BITS-1:0]  in_pos_y,
  input  wire logic signed [COORD_BITS-1:0]  in_pos_z,
  input  wire logic [GRAIN_LABEL_BITS-1:0]   in_grain_label,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_inside_box,
  output logic                               out_on_face,
  output logic                               out_label_out_of_range,
  output logic                               out_label_is_boundary,
  output logic [COUNT_BITS-1:0]              out_label_pixels,
  output logic [LABEL_BITS:0]                out_interior_labels,
  output logic [LABEL_BITS:0]                out_boundary_labels
);

  localparam int DEPTH      = 2 ** LABEL_BITS;
  localparam int ENTRY_BITS = COUNT_BITS + 1;
  localparam int TOTAL_BITS = LABEL_BITS + 1;

  // Table entry: {mark, count}
  logic [ENTRY_BITS-1:0] table_mem [DEPTH];
  logic [ENTRY_BITS-1:0] rd_data_r;

  logic [LABEL_BITS-1:0]        clr_addr_r;
  logic signed [COORD_BITS-1:0] pos_r [3];
  logic [LABEL_BITS-1:0]        idx_r;
  logic                         bad_r;
  logic [TOTAL_BITS-1:0]        interior_total_r;
  logic [TOTAL_BITS-1:0]        boundary_total_r;

  logic                         out_valid_r;
  logic                         out_inside_r;
  logic                         out_face_r;
  logic                         out_bad_r;
  logic                         out_mark_r;
  logic [COUNT_BITS-1:0]        out_cnt_r;

  logic                         box_hit;
  logic                         face;
  logic                         rd_mark;
  logic [COUNT_BITS-1:0]        rd_cnt;
  logic                         do_mark;
  logic                         do_count;
  logic                         new_mark;
  logic [COUNT_BITS-1:0]        new_cnt;
  logic [TOTAL_BITS-1:0]        interior_nxt;
  logic [TOTAL_BITS-1:0]        boundary_nxt;
  logic                         wr_en;
  logic [LABEL_BITS-1:0]        wr_addr;
  logic [ENTRY_BITS-1:0]        wr_data;

  assign rd_mark = rd_data_r[COUNT_BITS];
  assign rd_cnt  = rd_data_r[COUNT_BITS-1:0];

  // Box test on the used axes
  always_comb begin
    box_hit = 1'b1;
    face    = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (a < 2 || three_dim) begin
        if (pos_r[a] < box_lo[a] || pos_r[a] > box_hi[a]) box_hit = 1'b0;
        if (pos_r[a] == box_lo[a] || pos_r[a] == box_hi[a]) face = 1'b1;
      end
    end
    face = face && box_hit;
  end

  // Mark or count decision and the entry after the step
  always_comb begin
    do_mark  = !bad_r && box_hit && (pass_mode == MODE_MARK) && face && !rd_mark;
    do_count = !bad_r && box_hit && (pass_mode == MODE_COUNT) && !rd_mark;
    new_mark = rd_mark || do_mark;
    new_cnt  = rd_cnt;
    if (do_count && (rd_cnt != '1)) new_cnt = rd_cnt + COUNT_BITS'(1);
    boundary_nxt = boundary_total_r;
    interior_nxt = interior_total_r;
    if (do_mark) begin
      boundary_nxt = boundary_total_r + TOTAL_BITS'(1);
      if (rd_cnt != '0) interior_nxt = interior_total_r - TOTAL_BITS'(1);
    end else if (do_count && (rd_cnt == '0)) begin
      interior_nxt = interior_total_r + TOTAL_BITS'(1);
    end
  end

  // Table write port: clearing sweep or committed update
  always_comb begin
    wr_en   = cmd.clear_en || (cmd.commit && (do_mark || do_count));
    wr_addr = cmd.clear_en ? clr_addr_r : idx_r;
    wr_data = cmd.clear_en ? '0 : {new_mark, new_cnt};
  end

  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
  end

  // Read the entry of the accepted label
  always_ff @(posedge clk) begin
    if (cmd.accept) rd_data_r <= table_mem[in_grain_label[LABEL_BITS-1:0]];
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
      idx_r    <= in_grain_label[LABEL_BITS-1:0];
      bad_r    <= |in_grain_label[GRAIN_LABEL_BITS-1:LABEL_BITS];
    end
  end

  // Advance the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_en) begin
      clr_addr_r <= clr_addr_r + LABEL_BITS'(1);
    end
  end

  // Totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interior_total_r <= '0;
      boundary_total_r <= '0;
    end else if (cmd.commit) begin
      interior_total_r <= interior_nxt;
      boundary_total_r <= boundary_nxt;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_inside_r <= box_hit;
      out_face_r   <= face;
      out_bad_r    <= bad_r;
      out_mark_r   <= bad_r ? 1'b0 : new_mark;
      out_cnt_r    <= bad_r ? '0 : new_cnt;
    end
  end

  assign sts.clear_done = (clr_addr_r == '1);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid              = out_valid_r;
  assign out_inside_box         = out_inside_r;
  assign out_on_face            = out_face_r;
  assign out_label_out_of_range = out_bad_r;
  assign out_label_is_boundary  = out_mark_r;
  assign out_label_pixels       = out_cnt_r;
  assign out_interior_labels    = interior_total_r;
  assign out_boundary_labels    = boundary_total_r;

endmodule

`default_nettype wire

@@ hw/rtl/interior_grain_pixel_counter_core.sv @@
// ----------------------------------------------------------------------------
// interior_grain_pixel_counter_core: masked label histogram
// Marks boundary grains and counts interior pixels per grain label.
// ----------------------------------------------------------------------------
// After reset the block sweeps its label table to zero, one entry per cycle,
// over all 2**LABEL_BITS entries (4096 by default); no item is accepted
// during the sweep, while configuration writes are taken at any time.
// Afterwards each voxel's accept cycle reads its label's table entry, and
// the update state does the read-modify-write of mark and count and loads
// the result register; a result held by the sink keeps the block in that
// state until the result register frees up. The next voxel may be accepted
// while a result waits to be taken. Write configuration only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module interior_grain_pixel_counter_core
  import igpc_pkg::*;
#(
  parameter int LABEL_BITS = LABEL_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  igpc_in_if.sink                       in_ch,
  igpc_out_if.source                    out_ch,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int TOTAL_BITS = LABEL_BITS + 1;

  logic signed [COORD_BITS-1:0] box_lo [3];
  logic signed [COORD_BITS-1:0] box_hi [3];
  logic                         three_dim;
  logic [1:0]                   pass_mode;
  igpc_cmd_t                    cmd;
  igpc_sts_t                    sts;

  igpc_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .box_lo    (box_lo),
    .box_hi    (box_hi),
    .three_dim (three_dim),
    .pass_mode (pass_mode)
  );

  igpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  igpc_dp #(
    .LABEL_BITS (LABEL_BITS),
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .box_lo                 (box_lo),
    .box_hi                 (box_hi),
    .three_dim              (three_dim),
    .pass_mode              (pass_mode),
    .in_pos_x               (in_ch.pos_x),
    .in_pos_y               (in_ch.pos_y),
    .in_pos_z               (in_ch.pos_z),
    .in_grain_label         (in_ch.grain_label),
    .out_valid              (out_ch.valid),
    .out_ready              (out_ch.ready),
    .out_inside_box         (out_ch.inside_box),
    .out_on_face            (out_ch.on_face),
    .out_label_out_of_range (out_ch.label_out_of_range),
    .out_label_is_boundary  (out_ch.label_is_boundary),
    .out_label_pixels       (out_ch.label_pixels),
    .out_interior_labels    (out_ch.interior_labels),
    .out_boundary_labels    (out_ch.boundary_labels)
  );

  // No item is taken while the table sweep runs
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_en |-> !in_ch.ready)
    else $error("item ready during table clearing");

  // A committed item shows up as a valid result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("committed item missing from result register");

  // Boundary and interior labels are disjoint subsets of the table
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      ((TOTAL_BITS + 1)'(out_ch.boundary_labels) +
       (TOTAL_BITS + 1)'(out_ch.interior_labels)) <=
      (TOTAL_BITS + 1)'(2 ** LABEL_BITS))
    else $error("label totals exceed table size");

  // Accept and commit never coincide
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.commit))
    else $error("accept and commit in the same cycle");

endmodule

`default_nettype wire
